// File: rtl/dlim_pkg.sv
// Package for the dual lamp interlock monitor.
// Holds register reset values, register indexes and the percent scale.
// No dependencies; used by the top level.
package dlim_pkg;

    localparam int unsigned UV_W    = 16;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned IN_W    = 72;
    localparam int unsigned OUT_W   = 8;

    // Product of peak and percent, and the scaled compare limit
    localparam int unsigned PROD_W  = UV_W + PCT_W;
    localparam int unsigned LIM_W   = PROD_W + 1;

    localparam logic [TEMP_W-1:0] RESET_OVERHEAT = 16'd55;
    localparam logic [TEMP_W-1:0] RESET_RECOVERY = 16'd20;
    localparam logic [PCT_W-1:0]  RESET_PERCENT  = 7'd20;
    localparam logic [UV_W-1:0]   RESET_FLOOR    = 16'd10;
    localparam logic [PCT_W-1:0]  PERCENT_DIV    = 7'd100;

    typedef enum logic [IDX_W-1:0] {
        REG_OVERHEAT = 2'd0,
        REG_RECOVERY = 2'd1,
        REG_PERCENT  = 2'd2,
        REG_FLOOR    = 2'd3
    } t_reg_idx;

endpackage

// File: rtl/dual_lamp_interlock_monitor_unit.sv
// Dual lamp interlock monitor, top level.
// Uses dlim_pkg for register reset values, indexes and widths.
//
// One input transfer is one poll of both lamp channels; each poll yields one
// output transfer with run, overheat and low-UV flags. The unit takes one poll
// per clock cycle while the output is not stalled: the poll is held in an
// input register, the peak tracking, start arbitration, overheat hysteresis
// and low-UV compare are evaluated combinationally from that register, and
// the flags land in the output register once it is free or is being read.
// A stalled output holds its result and the input register,
// and the input side stalls only while both registers are full. The
// per-channel feedback (peak, on state, overheat flag) is updated at the same
// edge that loads the output register, which is what lets the next poll
// follow directly. The low-UV test compares peak * percent against
// 100 * (uv + 1), so no divider is needed. Registers are written through a
// plain write port and should only change while no poll is in flight.
module dual_lamp_interlock_monitor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Poll input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] uv_a, [31:16] uv_b, [47:32] temp_a, [63:48] temp_b,
    // [64] button_a, [65] button_b, [66] clear_a, [67] clear_b, [71:68] zero
    input  logic [71:0] i_s_axis_tdata,
    // Result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] run_a, [1] run_b, [2] heat_alarm_a, [3] heat_alarm_b,
    // [4] uv_alarm_a, [5] uv_alarm_b, [7:6] zero
    output logic [7:0]  o_m_axis_tdata
);

    // Configuration registers
    logic [dlim_pkg::TEMP_W-1:0] r_overheat;
    logic [dlim_pkg::TEMP_W-1:0] r_recovery;
    logic [dlim_pkg::PCT_W-1:0]  r_percent;
    logic [dlim_pkg::UV_W-1:0]   r_floor;

    // Channel state
    logic [dlim_pkg::UV_W-1:0] r_peak_a, r_peak_b;
    logic                      r_active_a, r_active_b;
    logic                      r_hot_a, r_hot_b;

    // Input stage
    logic                        r_in_valid;
    logic [dlim_pkg::IN_W-1:0]   r_in_data;

    // Output stage
    logic                        r_out_valid;
    logic [dlim_pkg::OUT_W-1:0]  r_out_data;

    logic advance;
    logic fire;

    logic [dlim_pkg::UV_W-1:0]   in_uv_a, in_uv_b;
    logic [dlim_pkg::TEMP_W-1:0] in_temp_a, in_temp_b;
    logic in_button_a, in_button_b, in_clear_a, in_clear_b;

    logic [dlim_pkg::UV_W-1:0]   n_peak_a, n_peak_b;
    logic [dlim_pkg::UV_W-1:0]   n_store_a, n_store_b;
    logic                        n_active_a, n_active_b;
    logic                        n_hot_a, n_hot_b;
    logic                        n_run_a, n_run_b;
    logic                        n_uv_alarm_a, n_uv_alarm_b;
    logic [dlim_pkg::PROD_W-1:0] prod_a, prod_b;
    logic [dlim_pkg::LIM_W-1:0]  lim_a, lim_b;

    // Handshake: the input stage moves on when the output register is free
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Unpack the held poll
    assign in_uv_a     = r_in_data[15:0];
    assign in_uv_b     = r_in_data[31:16];
    assign in_temp_a   = r_in_data[47:32];
    assign in_temp_b   = r_in_data[63:48];
    assign in_button_a = r_in_data[64];
    assign in_button_b = r_in_data[65];
    assign in_clear_a  = r_in_data[66];
    assign in_clear_b  = r_in_data[67];

    // Evaluate one poll
    always_comb begin
        // Track peaks with the new readings
        n_peak_a = (in_uv_a > r_peak_a) ? in_uv_a : r_peak_a;
        n_peak_b = (in_uv_b > r_peak_b) ? in_uv_b : r_peak_b;

        // Arbitrate start: channel a wins unless b was already on
        n_active_a = r_active_b ? 1'b0 : in_button_a;
        n_active_b = n_active_a ? 1'b0 : in_button_b;

        // Gate run with the previous overheat flags
        n_run_a = n_active_a && !r_hot_a;
        n_run_b = n_active_b && !r_hot_b;

        // Overheat hysteresis
        n_hot_a = (r_hot_a || (in_temp_a > r_overheat)) && (in_temp_a > r_recovery);
        n_hot_b = (r_hot_b || (in_temp_b > r_overheat)) && (in_temp_b > r_recovery);

        // Low UV: floor(peak*pct/100) > uv  <=>  peak*pct >= 100*(uv+1)
        prod_a = dlim_pkg::PROD_W'(n_peak_a) * dlim_pkg::PROD_W'(r_percent);
        prod_b = dlim_pkg::PROD_W'(n_peak_b) * dlim_pkg::PROD_W'(r_percent);
        lim_a  = dlim_pkg::LIM_W'(in_uv_a) * dlim_pkg::LIM_W'(dlim_pkg::PERCENT_DIV)
                 + dlim_pkg::LIM_W'(dlim_pkg::PERCENT_DIV);
        lim_b  = dlim_pkg::LIM_W'(in_uv_b) * dlim_pkg::LIM_W'(dlim_pkg::PERCENT_DIV)
                 + dlim_pkg::LIM_W'(dlim_pkg::PERCENT_DIV);
        n_uv_alarm_a = n_active_a && (dlim_pkg::LIM_W'(prod_a) >= lim_a);
        n_uv_alarm_b = n_active_b && (dlim_pkg::LIM_W'(prod_b) >= lim_b);

        // Apply clears after the alarm is evaluated
        n_store_a = in_clear_a ? r_floor : n_peak_a;
        n_store_b = in_clear_b ? r_floor : n_peak_b;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overheat <= dlim_pkg::RESET_OVERHEAT;
            r_recovery <= dlim_pkg::RESET_RECOVERY;
            r_percent  <= dlim_pkg::RESET_PERCENT;
            r_floor    <= dlim_pkg::RESET_FLOOR;
        end else if (i_cfg_we) begin
            unique case (dlim_pkg::t_reg_idx'(i_cfg_addr))
                dlim_pkg::REG_OVERHEAT: r_overheat <= i_cfg_wdata;
                dlim_pkg::REG_RECOVERY: r_recovery <= i_cfg_wdata;
                dlim_pkg::REG_PERCENT:  r_percent  <= i_cfg_wdata[dlim_pkg::PCT_W-1:0];
                dlim_pkg::REG_FLOOR:    r_floor    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel state, updated as each poll moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_a   <= dlim_pkg::RESET_FLOOR;
            r_peak_b   <= dlim_pkg::RESET_FLOOR;
            r_active_a <= 1'b0;
            r_active_b <= 1'b0;
            r_hot_a    <= 1'b0;
            r_hot_b    <= 1'b0;
        end else if (fire) begin
            r_peak_a   <= n_store_a;
            r_peak_b   <= n_store_b;
            r_active_a <= n_active_a;
            r_active_b <= n_active_b;
            r_hot_a    <= n_hot_a;
            r_hot_b    <= n_hot_b;
        end
    end

    // Input register: capture a transfer whenever there is room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    // Output register: hold until the downstream side takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {2'b00, n_uv_alarm_b, n_uv_alarm_a, n_hot_b, n_hot_a,
                           n_run_b, n_run_a};
        end
    end

endmodule

// File: rtl/dlim_checker.sv
// Port-level checker for the dual lamp interlock monitor.
// Depends on dual_lamp_interlock_monitor_unit; bound to it at the end of this file.
module dlim_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Starts are mutually exclusive
    a_one_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("both channels running");

    // Low UV alarm only on the single active channel
    a_one_uv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[4] && o_m_axis_tdata[5]))
        else $error("UV alarm on both channels");

    // With the output empty, the input side always accepts
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with output empty");

endmodule

bind dual_lamp_interlock_monitor_unit dlim_port_checker u_dlim_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
